@@ rtl/core/mts_pkg.sv @@
// shared types, constants and helpers of the mipmap texture sampler
package mts_pkg;

  localparam int MAX_SIZE        = 256;
  localparam int COORD_FRAC_BITS = 8;
  localparam int LOD_FRAC_BITS   = 8;
  localparam int STORE_WORDS_DEF = 8192;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [2:0] CFG_SIZE_X          = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y          = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z          = 3'd2;
  localparam logic [2:0] CFG_MIP_LEVELS      = 3'd3;
  localparam logic [2:0] CFG_CHANNEL_COUNT   = 3'd4;
  localparam logic [2:0] CFG_SIGNED_ELEMENTS = 3'd5;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [8:0] sx;
    logic [8:0] sy;
    logic [8:0] sz;
    logic [8:0] sy_sat;
    logic [8:0] sz_sat;
    logic [3:0] nl;
    logic [2:0] nc;
    logic       sgn;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic             oob;
    logic [19:0]      cx;
    logic [19:0]      cy;
    logic [19:0]      cz;
    logic [11:0]      lod;
    logic [3:0][31:0] texel;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LVL,
    ST_GA,
    ST_GB,
    ST_GC,
    ST_GD,
    ST_AXS,
    ST_AXW,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_A4,
    ST_WR,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    AX_IDLE,
    AX_MUL,
    AX_LD1,
    AX_DIV1,
    AX_FRAC,
    AX_DIV2,
    AX_DONE
  } axis_state_t;

  function automatic logic [8:0] sat_size(input logic [8:0] v);
    logic [8:0] r;
    r = (32'(v) > MAX_SIZE) ? 9'(MAX_SIZE) : v;
    return r;
  endfunction

  function automatic logic [8:0] dim_at(input logic [8:0] s, input logic [3:0] l);
    logic [8:0] d;
    d = s >> l;
    return (d == '0) ? 9'd1 : d;
  endfunction

endpackage

@@ rtl/core/mipmap_texture_sampler_top.sv @@
// top level of the mipmap texture sampler: configuration registers and front/back
// Items enter a two-entry queue, where they are checked against the current
// configuration, and a sequencer carries them out one at a time. A write walks
// the level chain to find the level base, forms the address, then writes one
// channel word a cycle through the single store port. A sample repeats for each
// of its one or two levels: the level walk, index and fraction division (one
// restoring divider per axis, one quotient bit a cycle, up to two divisions
// each), then eight corners of weights, address, and read, multiply, accumulate
// for each channel. Items marked out of bounds at the queue skip straight to
// the result. The result register holds one result while the queue keeps
// taking new items.
module mipmap_texture_sampler_top #(
  parameter int STORE_WORDS = mts_pkg::STORE_WORDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coord_x, coord_y, coord_z, detail_level, texel_c0, texel_c1, texel_c2, texel_c3
  input  logic [207:0] in_tdata,
  // operation
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_c0, result_c1, result_c2, result_c3
  output logic [127:0] out_tdata,
  // out_of_bounds
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [8:0]   cfg_wdata
);

  logic [8:0] size_x_r, size_y_r, size_z_r;
  logic [3:0] mip_levels_r;
  logic [2:0] channel_count_r;
  logic       signed_r;

  mts_pkg::cfg_t  cfg;
  logic           q_valid, q_ready;
  mts_pkg::item_t q_item;
  logic [8:0]     sx_sat, sy_sat, sz_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r        <= 9'd1;
      size_y_r        <= 9'd0;
      size_z_r        <= 9'd0;
      mip_levels_r    <= 4'd1;
      channel_count_r <= 3'd4;
      signed_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mts_pkg::CFG_SIZE_X:          size_x_r        <= cfg_wdata;
        mts_pkg::CFG_SIZE_Y:          size_y_r        <= cfg_wdata;
        mts_pkg::CFG_SIZE_Z:          size_z_r        <= cfg_wdata;
        mts_pkg::CFG_MIP_LEVELS:      mip_levels_r    <= cfg_wdata[3:0];
        mts_pkg::CFG_CHANNEL_COUNT:   channel_count_r <= cfg_wdata[2:0];
        mts_pkg::CFG_SIGNED_ELEMENTS: signed_r        <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign sx_sat = mts_pkg::sat_size(size_x_r);
  assign sy_sat = mts_pkg::sat_size(size_y_r);
  assign sz_sat = mts_pkg::sat_size(size_z_r);

  always_comb begin
    cfg.sx     = (sx_sat == '0) ? 9'd1 : sx_sat;
    cfg.sy     = (sy_sat == '0) ? 9'd1 : sy_sat;
    cfg.sz     = (sz_sat == '0) ? 9'd1 : sz_sat;
    cfg.sy_sat = sy_sat;
    cfg.sz_sat = sz_sat;
    cfg.nl     = (mip_levels_r == '0) ? 4'd1 : mip_levels_r;
    cfg.nc     = (channel_count_r == '0) ? 3'd1 :
                 ((channel_count_r > 3'd4) ? 3'd4 : channel_count_r);
    cfg.sgn    = signed_r;
  end

  mts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  mts_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/core/mts_ram.sv @@
// generic single-port ram with registered read
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/mts_axis.sv @@
// per-axis texel index and blend fraction unit with a shared restoring divider
module mts_axis (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] c,
  input  logic [8:0]  s,
  input  logic [3:0]  l,
  input  logic [8:0]  t,
  output logic [7:0]  i0,
  output logic [7:0]  i1,
  output logic [15:0] w1,
  output logic        done
);

  mts_pkg::axis_state_t state_r, state_nxt;

  logic [25:0] p_r;
  logic [23:0] dvd_r;
  logic [8:0]  rem_r;
  logic [4:0]  cnt_r;
  logic [7:0]  i0_r, i1_r;
  logic        frac_on_r;

  logic [9:0]  trial;
  logic        ge;
  logic [9:0]  rem_sub;
  logic        last_step;

  logic [8:0]  tm1;
  logic [8:0]  idx;
  logic [9:0]  idx1;
  logic [30:0] u31, m31, lhs, rhs, num;
  logic        cond;

  assign trial     = {rem_r, dvd_r[23]};
  assign ge        = trial >= {1'b0, s};
  assign rem_sub   = ge ? (trial - {1'b0, s}) : trial;
  assign last_step = cnt_r == 5'd23;

  assign tm1  = t - 9'd1;
  assign idx  = (dvd_r > 24'(tm1)) ? tm1 : dvd_r[8:0];
  assign idx1 = {1'b0, idx} + 10'd1;
  assign u31  = 31'({rem_r[7:0], p_r[7:0]});
  assign m31  = 31'({s, 8'h00});
  assign lhs  = u31 << l;
  assign rhs  = (m31 << l) - m31;
  assign cond = lhs > rhs;
  assign num  = m31 - ((m31 - u31) << l);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mts_pkg::AX_IDLE: if (start) state_nxt = mts_pkg::AX_MUL;
      mts_pkg::AX_MUL:  state_nxt = mts_pkg::AX_LD1;
      mts_pkg::AX_LD1:  state_nxt = mts_pkg::AX_DIV1;
      mts_pkg::AX_DIV1: if (last_step) state_nxt = mts_pkg::AX_FRAC;
      mts_pkg::AX_FRAC: state_nxt = cond ? mts_pkg::AX_DIV2 : mts_pkg::AX_DONE;
      mts_pkg::AX_DIV2: if (last_step) state_nxt = mts_pkg::AX_DONE;
      mts_pkg::AX_DONE: if (start) state_nxt = mts_pkg::AX_MUL;
      default:          state_nxt = mts_pkg::AX_IDLE;
    endcase
  end

  always_comb begin
    done = state_r == mts_pkg::AX_DONE;
    i0   = i0_r;
    i1   = i1_r;
    w1   = frac_on_r ? dvd_r[15:0] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mts_pkg::AX_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      mts_pkg::AX_MUL: begin
        p_r <= c * t;
      end
      mts_pkg::AX_LD1: begin
        dvd_r     <= {6'd0, p_r[25:8]};
        rem_r     <= '0;
        cnt_r     <= '0;
        frac_on_r <= 1'b0;
      end
      mts_pkg::AX_DIV1, mts_pkg::AX_DIV2: begin
        rem_r <= rem_sub[8:0];
        dvd_r <= {dvd_r[22:0], ge};
        cnt_r <= cnt_r + 5'd1;
      end
      mts_pkg::AX_FRAC: begin
        i0_r      <= idx[7:0];
        i1_r      <= (idx1 < {1'b0, t}) ? idx1[7:0] : tm1[7:0];
        frac_on_r <= cond;
        dvd_r     <= {num[15:0], 8'h00};
        rem_r     <= '0;
        cnt_r     <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/mts_front.sv @@
// input classification and bounds checks feeding a short item queue
module mts_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mts_pkg::cfg_t        cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [207:0]         in_tdata,
  input  logic [0:0]           in_tuser,
  output logic                 q_valid,
  input  logic                 q_ready,
  output mts_pkg::item_t       q_item
);

  localparam int PTR_W = (mts_pkg::QUEUE_DEPTH > 1) ? $clog2(mts_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mts_pkg::QUEUE_DEPTH + 1);

  mts_pkg::item_t item;
  mts_pkg::item_t q_mem_r [mts_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic neg, s_oob, w_oob, push, pop;

  assign neg   = in_tdata[20] | in_tdata[41] | in_tdata[62];
  assign s_oob = (in_tdata[19:0] > (20'(cfg.sx) << mts_pkg::COORD_FRAC_BITS)) ||
                 (in_tdata[40:21] > (20'(cfg.sy_sat) << mts_pkg::COORD_FRAC_BITS)) ||
                 (in_tdata[61:42] > (20'(cfg.sz_sat) << mts_pkg::COORD_FRAC_BITS)) ||
                 (in_tdata[74:63] > (12'(cfg.nl) << mts_pkg::LOD_FRAC_BITS));
  assign w_oob = in_tdata[74:71] >= cfg.nl;

  always_comb begin
    item.op       = in_tuser[0];
    item.oob      = neg | ((in_tuser[0] == mts_pkg::OP_SAMPLE) ? s_oob : w_oob);
    item.cx       = in_tdata[19:0];
    item.cy       = in_tdata[40:21];
    item.cz       = in_tdata[61:42];
    item.lod      = in_tdata[74:63];
    item.texel[0] = in_tdata[106:75];
    item.texel[1] = in_tdata[138:107];
    item.texel[2] = in_tdata[170:139];
    item.texel[3] = in_tdata[202:171];
  end

  assign in_tready = count_r != CNT_W'(mts_pkg::QUEUE_DEPTH);
  assign q_valid   = count_r != '0;
  assign q_item    = q_mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == mts_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == mts_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/mts_back.sv @@
// execution sequencer: level geometry, texel write and fetch, weighting and accumulation
module mts_back #(
  parameter int STORE_WORDS = mts_pkg::STORE_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mts_pkg::cfg_t  cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  mts_pkg::item_t q_item,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [127:0]   out_tdata,
  output logic [0:0]     out_tuser
);

  localparam int AW = $clog2(STORE_WORDS);

  mts_pkg::back_state_t state_r, state_nxt;
  mts_pkg::item_t item_r;

  logic        lvl_k_r;
  logic [3:0]  lvl_l_r, geo_k_r;
  logic [16:0] lw_r, w_r;
  logic [31:0] base_r;
  logic [17:0] m1_r;
  logic [26:0] m2_r;
  logic [29:0] vol_r;
  logic [8:0]  dx_r, dy_r, dz_r;
  logic [2:0]  corner_r;
  logic [17:0] t1_r;
  logic [26:0] t2_r;
  logic [29:0] t3_r;
  logic [AW-1:0] addr_r;
  logic [1:0]  ch_r;
  logic signed [50:0] prod_r;
  logic signed [55:0] sums_r [4];
  logic        oob_r;
  logic [127:0] out_data_r;
  logic        out_user_r;

  logic [8:0]  dxk, dyk, dzk;
  logic [17:0] m1_c;
  logic [26:0] m2_c;
  logic [29:0] vol_c;
  logic        geo_more, fit, range_bad, last_ch, is_write;
  logic [4:0]  lsum;
  logic [3:0]  nlm1, lvl_c;
  logic [16:0] lw_c, lfrac_w;
  logic [16:0] wsel;
  logic [33:0] wprod;
  logic [7:0]  xsel, ysel, zsel;
  logic [16:0] yz_c;
  logic [26:0] xt_c;
  logic [29:0] t3_c;
  logic [31:0] rdata;
  logic signed [32:0] data33;
  logic signed [50:0] prod_c;
  logic [55:0] adj [4];

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata;
  logic          ax_start;
  logic [16:0]   ax_c [3];
  logic [8:0]    ax_s [3];
  logic [8:0]    ax_t [3];
  logic [7:0]    ax_i0 [3];
  logic [7:0]    ax_i1 [3];
  logic [15:0]   ax_w1 [3];
  logic [2:0]    ax_done;

  assign dxk   = mts_pkg::dim_at(cfg.sx, geo_k_r);
  assign dyk   = mts_pkg::dim_at(cfg.sy, geo_k_r);
  assign dzk   = mts_pkg::dim_at(cfg.sz, geo_k_r);
  assign m1_c  = dxk * dyk;
  assign m2_c  = m1_r * dzk;
  assign vol_c = m2_r * cfg.nc;

  assign is_write  = item_r.op == mts_pkg::OP_WRITE;
  assign geo_more  = geo_k_r < lvl_l_r;
  assign fit       = (34'(base_r) + 34'(vol_r)) <= 34'(STORE_WORDS);
  assign range_bad = (item_r.cx[19:8] >= 12'(dxk)) || (item_r.cy[19:8] >= 12'(dyk)) ||
                     (item_r.cz[19:8] >= 12'(dzk));
  assign last_ch   = {1'b0, ch_r} == (cfg.nc - 3'd1);

  assign lsum    = {1'b0, item_r.lod[11:8]} + {4'd0, lvl_k_r};
  assign nlm1    = cfg.nl - 4'd1;
  assign lvl_c   = (lsum > {1'b0, nlm1}) ? nlm1 : lsum[3:0];
  assign lfrac_w = {1'b0, item_r.lod[7:0], 8'h00};
  assign lw_c    = lvl_k_r ? lfrac_w : (17'h10000 - lfrac_w);

  always_comb begin
    unique case (state_r)
      mts_pkg::ST_W1: wsel = corner_r[0] ? {1'b0, ax_w1[0]} : (17'h10000 - {1'b0, ax_w1[0]});
      mts_pkg::ST_W2: wsel = corner_r[1] ? {1'b0, ax_w1[1]} : (17'h10000 - {1'b0, ax_w1[1]});
      default:        wsel = corner_r[2] ? {1'b0, ax_w1[2]} : (17'h10000 - {1'b0, ax_w1[2]});
    endcase
  end
  assign wprod = ((state_r == mts_pkg::ST_W1) ? lw_r : w_r) * wsel;

  assign xsel = is_write ? item_r.cx[15:8] : (corner_r[0] ? ax_i1[0] : ax_i0[0]);
  assign ysel = is_write ? item_r.cy[15:8] : (corner_r[1] ? ax_i1[1] : ax_i0[1]);
  assign zsel = is_write ? item_r.cz[15:8] : (corner_r[2] ? ax_i1[2] : ax_i0[2]);
  assign yz_c = dy_r * zsel;
  assign xt_c = dx_r * t1_r;
  assign t3_c = t2_r * cfg.nc;

  assign data33 = {cfg.sgn & rdata[31], rdata};
  assign prod_c = data33 * $signed({1'b0, w_r});

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      adj[i] = sums_r[i] + (sums_r[i][55] ? 56'hFFFF : 56'h0);
    end
  end

  assign ax_c[0] = item_r.cx[16:0];
  assign ax_c[1] = item_r.cy[16:0];
  assign ax_c[2] = item_r.cz[16:0];
  assign ax_s[0] = cfg.sx;
  assign ax_s[1] = cfg.sy;
  assign ax_s[2] = cfg.sz;
  assign ax_t[0] = dx_r;
  assign ax_t[1] = dy_r;
  assign ax_t[2] = dz_r;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    mts_axis u_axis (
      .clk   (clk),
      .rst_n (rst_n),
      .start (ax_start),
      .c     (ax_c[a]),
      .s     (ax_s[a]),
      .l     (lvl_l_r),
      .t     (ax_t[a]),
      .i0    (ax_i0[a]),
      .i1    (ax_i1[a]),
      .w1    (ax_w1[a]),
      .done  (ax_done[a])
    );
  end

  mts_ram #(
    .WIDTH (32),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mts_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.oob) begin
            state_nxt = mts_pkg::ST_FIN;
          end else if (q_item.op == mts_pkg::OP_WRITE) begin
            state_nxt = mts_pkg::ST_GA;
          end else begin
            state_nxt = mts_pkg::ST_LVL;
          end
        end
      end
      mts_pkg::ST_LVL: state_nxt = (lw_c == '0) ? mts_pkg::ST_FIN : mts_pkg::ST_GA;
      mts_pkg::ST_GA:  state_nxt = mts_pkg::ST_GB;
      mts_pkg::ST_GB:  state_nxt = mts_pkg::ST_GC;
      mts_pkg::ST_GC:  state_nxt = mts_pkg::ST_GD;
      mts_pkg::ST_GD: begin
        priority if (geo_more) begin
          state_nxt = mts_pkg::ST_GA;
        end else if (!fit) begin
          state_nxt = mts_pkg::ST_FIN;
        end else if (is_write) begin
          state_nxt = range_bad ? mts_pkg::ST_FIN : mts_pkg::ST_A1;
        end else begin
          state_nxt = mts_pkg::ST_AXS;
        end
      end
      mts_pkg::ST_AXS: state_nxt = mts_pkg::ST_AXW;
      mts_pkg::ST_AXW: if (&ax_done) state_nxt = mts_pkg::ST_W1;
      mts_pkg::ST_W1:  state_nxt = mts_pkg::ST_W2;
      mts_pkg::ST_W2:  state_nxt = mts_pkg::ST_W3;
      mts_pkg::ST_W3:  state_nxt = mts_pkg::ST_A1;
      mts_pkg::ST_A1:  state_nxt = mts_pkg::ST_A2;
      mts_pkg::ST_A2:  state_nxt = mts_pkg::ST_A3;
      mts_pkg::ST_A3:  state_nxt = mts_pkg::ST_A4;
      mts_pkg::ST_A4:  state_nxt = is_write ? mts_pkg::ST_WR : mts_pkg::ST_RD;
      mts_pkg::ST_WR:  if (last_ch) state_nxt = mts_pkg::ST_FIN;
      mts_pkg::ST_RD:  state_nxt = mts_pkg::ST_MUL;
      mts_pkg::ST_MUL: state_nxt = mts_pkg::ST_ACC;
      mts_pkg::ST_ACC: begin
        priority if (!last_ch) begin
          state_nxt = mts_pkg::ST_RD;
        end else if (corner_r != 3'd7) begin
          state_nxt = mts_pkg::ST_W1;
        end else if (!lvl_k_r) begin
          state_nxt = mts_pkg::ST_LVL;
        end else begin
          state_nxt = mts_pkg::ST_FIN;
        end
      end
      mts_pkg::ST_FIN: state_nxt = mts_pkg::ST_OUT;
      mts_pkg::ST_OUT: if (out_tready) state_nxt = mts_pkg::ST_IDLE;
      default:         state_nxt = mts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready    = state_r == mts_pkg::ST_IDLE;
    ram_we     = state_r == mts_pkg::ST_WR;
    ram_addr   = addr_r + AW'(ch_r);
    ram_wdata  = item_r.texel[ch_r];
    ax_start   = state_r == mts_pkg::ST_AXS;
    out_tvalid = state_r == mts_pkg::ST_OUT;
    out_tdata  = out_data_r;
    out_tuser  = out_user_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      mts_pkg::ST_IDLE: begin
        item_r  <= q_item;
        oob_r   <= q_item.oob;
        lvl_k_r <= 1'b0;
        lvl_l_r <= q_item.lod[11:8];
        geo_k_r <= '0;
        base_r  <= '0;
        for (int i = 0; i < 4; i++) begin
          sums_r[i] <= '0;
        end
      end
      mts_pkg::ST_LVL: begin
        lvl_l_r <= lvl_c;
        lw_r    <= lw_c;
        geo_k_r <= '0;
        base_r  <= '0;
      end
      mts_pkg::ST_GA: m1_r  <= m1_c;
      mts_pkg::ST_GB: m2_r  <= m2_c;
      mts_pkg::ST_GC: vol_r <= vol_c;
      mts_pkg::ST_GD: begin
        if (geo_more) begin
          base_r  <= base_r + 32'(vol_r);
          geo_k_r <= geo_k_r + 4'd1;
        end else begin
          dx_r <= dxk;
          dy_r <= dyk;
          dz_r <= dzk;
          if (!fit || (is_write && range_bad)) begin
            oob_r <= 1'b1;
          end
        end
        corner_r <= '0;
      end
      mts_pkg::ST_W1, mts_pkg::ST_W2, mts_pkg::ST_W3: w_r <= wprod[32:16];
      mts_pkg::ST_A1: begin
        t1_r <= 18'(yz_c) + 18'(ysel);
        ch_r <= '0;
      end
      mts_pkg::ST_A2: t2_r   <= xt_c + 27'(xsel);
      mts_pkg::ST_A3: t3_r   <= t3_c;
      mts_pkg::ST_A4: addr_r <= AW'(base_r + 32'(t3_r));
      mts_pkg::ST_WR: ch_r   <= ch_r + 2'd1;
      mts_pkg::ST_MUL: prod_r <= prod_c;
      mts_pkg::ST_ACC: begin
        sums_r[ch_r] <= sums_r[ch_r] + 56'(prod_r);
        if (!last_ch) begin
          ch_r <= ch_r + 2'd1;
        end else if (corner_r != 3'd7) begin
          corner_r <= corner_r + 3'd1;
        end else begin
          lvl_k_r <= 1'b1;
        end
      end
      mts_pkg::ST_FIN: begin
        out_user_r <= oob_r;
        if (oob_r || is_write) begin
          out_data_r <= '0;
        end else begin
          out_data_r <= {adj[3][47:16], adj[2][47:16], adj[1][47:16], adj[0][47:16]};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("rejected transaction carries nonzero data");

  a_we_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (item_r.op == mts_pkg::OP_WRITE) && !oob_r)
    else $error("store written outside an accepted write");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we || state_r == mts_pkg::ST_RD) |-> 32'(ram_addr) < 32'(STORE_WORDS))
    else $error("store address beyond depth");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready |=> state_r != mts_pkg::ST_IDLE)
    else $error("taken item did not start");
`endif

endmodule
